>>> rtl/blocked_duct_detector_assert.svh
// ---------------------------------------------------------------------------
// Blocked duct detector assertion macros
// Shared property forms for the concurrent checks of the detector.
// ---------------------------------------------------------------------------
`ifndef BLOCKED_DUCT_DETECTOR_ASSERT_SVH
`define BLOCKED_DUCT_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blocked duct detector: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blocked duct detector: next-cycle check failed");

`endif

>>> rtl/bdd_pkg.sv
// ---------------------------------------------------------------------------
// Blocked duct detector package
// Widths, fit coefficients, band limits, margins and stage payload types.
// ---------------------------------------------------------------------------
package bdd_pkg;

  localparam int SPEED_W  = 12;
  localparam int LOW_W    = 9;
  localparam int DUTY_W   = 16;
  localparam int MARGIN_W = 11;
  localparam int H1_W     = 23;
  localparam int H2_W     = 34;
  localparam int H3_W     = 43;
  localparam int ACC_W    = 55;
  localparam int FRAC_W   = 24;
  localparam int EXP_W    = ACC_W - FRAC_W;
  localparam int LHS_W    = 41;
  localparam int CMP_W    = 42;

  localparam logic [SPEED_W-1:0] SPEED_MAX = 12'd4095;

  // Band limits in rpm.
  localparam logic [SPEED_W-1:0] LIM_LOW = 12'd350;
  localparam logic [SPEED_W-1:0] LIM_B1  = 12'd700;
  localparam logic [SPEED_W-1:0] LIM_B2  = 12'd800;
  localparam logic [SPEED_W-1:0] LIM_B3  = 12'd1250;
  localparam logic [SPEED_W-1:0] LIM_B4  = 12'd1550;

  // Margins in thousandths.
  localparam logic [MARGIN_W-1:0] M_LOW = 11'd1010;
  localparam logic [MARGIN_W-1:0] M_B1  = 11'd1001;
  localparam logic [MARGIN_W-1:0] M_B2  = 11'd1050;
  localparam logic [MARGIN_W-1:0] M_B3  = 11'd1100;
  localparam logic [MARGIN_W-1:0] M_B4  = 11'd1130;
  localparam logic [MARGIN_W-1:0] M_TOP = 11'd1100;

  // Fit coefficients in Q.48, rounded to nearest.
  localparam logic [H1_W-1:0]  Q48_A  = 23'd844;
  localparam logic [H1_W-1:0]  Q48_B  = 23'd5629500;
  localparam logic [H2_W-1:0]  Q48_C  = 34'd8444249301;
  localparam logic [H3_W-1:0]  Q48_D  = 43'd3096224743817;
  localparam logic [ACC_W-1:0] Q48_E  = 55'd2040665433654585;
  localparam logic [ACC_W-1:0] Q48_L1 = 55'd7149464408451;
  localparam logic [ACC_W-1:0] Q48_L0 = 55'd2152748769380768;

  localparam logic [ACC_W-1:0] ROUND_HALF = 55'd8388608;

  // Duty scale: 100 percent, 2^8 to reach Q.24, 1000 for the margin.
  localparam logic [LHS_W-1:0] DUTY_SCALE = 41'd25600000;

  typedef struct packed {
    logic                low;
    logic [LOW_W-1:0]    s9;
    logic [MARGIN_W-1:0] margin;
    logic [DUTY_W-1:0]   duty;
    logic [H1_W-1:0]     h1;
    logic [ACC_W-1:0]    lin;
  } s1_t;

  typedef struct packed {
    logic [MARGIN_W-1:0] margin;
    logic [DUTY_W-1:0]   duty;
    logic [ACC_W-1:0]    acc;
  } acc_t;

endpackage

>>> rtl/bdd_flow.sv
// ---------------------------------------------------------------------------
// Blocked duct detector pipeline flow control
// Per-stage valid bits and a ready chain that lets bubbles collapse on stall.
// ---------------------------------------------------------------------------
module bdd_flow #(
  parameter int NSTAGE = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic [NSTAGE-1:0] en,
  output logic [NSTAGE-1:0] vld_r
);

  logic [NSTAGE-1:0] vld_nxt;
  logic [NSTAGE-1:0] rdy;

  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign en       = rdy;
  assign in_ready = rdy[0];

endmodule

>>> rtl/bdd_front.sv
// ---------------------------------------------------------------------------
// Blocked duct detector front stage
// Saturates a wider speed to 12 bits, picks the band margin and starts both fits.
// ---------------------------------------------------------------------------
module bdd_front #(
  parameter int SPEED_BITS = 12
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [SPEED_BITS-1:0]         speed,
  input  logic [bdd_pkg::DUTY_W-1:0]    duty,
  output bdd_pkg::s1_t                  s1_r
);

  logic [bdd_pkg::SPEED_W-1:0] sat;
  bdd_pkg::s1_t                s1_nxt;

  generate
    if (SPEED_BITS > bdd_pkg::SPEED_W) begin : g_sat
      assign sat = (speed > SPEED_BITS'(bdd_pkg::SPEED_MAX)) ? bdd_pkg::SPEED_MAX
                                                             : speed[bdd_pkg::SPEED_W-1:0];
    end else begin : g_ext
      assign sat = bdd_pkg::SPEED_W'(speed);
    end
  endgenerate

  always_comb begin
    s1_nxt.low  = sat < bdd_pkg::LIM_LOW;
    s1_nxt.s9   = sat[bdd_pkg::LOW_W-1:0];
    s1_nxt.duty = duty;
    priority if (sat < bdd_pkg::LIM_LOW) begin
      s1_nxt.margin = bdd_pkg::M_LOW;
    end else if (sat <= bdd_pkg::LIM_B1) begin
      s1_nxt.margin = bdd_pkg::M_B1;
    end else if (sat <= bdd_pkg::LIM_B2) begin
      s1_nxt.margin = bdd_pkg::M_B2;
    end else if (sat <= bdd_pkg::LIM_B3) begin
      s1_nxt.margin = bdd_pkg::M_B3;
    end else if (sat <= bdd_pkg::LIM_B4) begin
      s1_nxt.margin = bdd_pkg::M_B4;
    end else begin
      s1_nxt.margin = bdd_pkg::M_TOP;
    end
    s1_nxt.h1  = bdd_pkg::Q48_A * bdd_pkg::H1_W'(s1_nxt.s9) + bdd_pkg::Q48_B;
    s1_nxt.lin = bdd_pkg::Q48_L1 * bdd_pkg::ACC_W'(sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

>>> rtl/bdd_poly.sv
// ---------------------------------------------------------------------------
// Blocked duct detector fit stages
// Three Horner steps of the quartic fit beside the linear fit, then selection.
// ---------------------------------------------------------------------------
module bdd_poly (
  input  logic         clk,
  input  logic [2:0]   en,
  input  bdd_pkg::s1_t s1,
  output bdd_pkg::acc_t acc_r
);

  typedef struct packed {
    logic                         low;
    logic [bdd_pkg::LOW_W-1:0]    s9;
    logic [bdd_pkg::MARGIN_W-1:0] margin;
    logic [bdd_pkg::DUTY_W-1:0]   duty;
    logic [bdd_pkg::H2_W-1:0]     h2;
    logic [bdd_pkg::ACC_W-1:0]    lin;
  } p2_t;

  typedef struct packed {
    logic                         low;
    logic [bdd_pkg::LOW_W-1:0]    s9;
    logic [bdd_pkg::MARGIN_W-1:0] margin;
    logic [bdd_pkg::DUTY_W-1:0]   duty;
    logic [bdd_pkg::H3_W-1:0]     h3;
    logic [bdd_pkg::ACC_W-1:0]    lin;
  } p3_t;

  p2_t           p2_r, p2_nxt;
  p3_t           p3_r, p3_nxt;
  bdd_pkg::acc_t acc_nxt;
  logic [bdd_pkg::ACC_W-1:0] h4;

  always_comb begin
    p2_nxt.low    = s1.low;
    p2_nxt.s9     = s1.s9;
    p2_nxt.margin = s1.margin;
    p2_nxt.duty   = s1.duty;
    p2_nxt.h2     = bdd_pkg::H2_W'(s1.h1) * bdd_pkg::H2_W'(s1.s9) + bdd_pkg::Q48_C;
    p2_nxt.lin    = s1.lin + bdd_pkg::Q48_L0;
  end

  always_comb begin
    p3_nxt.low    = p2_r.low;
    p3_nxt.s9     = p2_r.s9;
    p3_nxt.margin = p2_r.margin;
    p3_nxt.duty   = p2_r.duty;
    p3_nxt.h3     = bdd_pkg::H3_W'(p2_r.h2) * bdd_pkg::H3_W'(p2_r.s9) + bdd_pkg::Q48_D;
    p3_nxt.lin    = p2_r.lin;
  end

  always_comb begin
    h4 = bdd_pkg::ACC_W'(p3_r.h3) * bdd_pkg::ACC_W'(p3_r.s9) + bdd_pkg::Q48_E;
    acc_nxt.margin = p3_r.margin;
    acc_nxt.duty   = p3_r.duty;
    acc_nxt.acc    = p3_r.low ? h4 : p3_r.lin;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p2_r <= p2_nxt;
    end
    if (en[1]) begin
      p3_r <= p3_nxt;
    end
    if (en[2]) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

>>> rtl/bdd_judge.sv
// ---------------------------------------------------------------------------
// Blocked duct detector decision stages
// Rounds the expected duty, scales both sides and compares them.
// ---------------------------------------------------------------------------
module bdd_judge (
  input  logic          clk,
  input  logic [2:0]    en,
  input  bdd_pkg::acc_t acc,
  output logic          flag_r
);

  typedef struct packed {
    logic [bdd_pkg::MARGIN_W-1:0] margin;
    logic [bdd_pkg::EXP_W-1:0]    expv;
    logic [bdd_pkg::LHS_W-1:0]    lhs;
  } j5_t;

  typedef struct packed {
    logic [bdd_pkg::CMP_W-1:0] rhs;
    logic [bdd_pkg::CMP_W-1:0] lhs;
  } j6_t;

  j5_t  j5_r, j5_nxt;
  j6_t  j6_r, j6_nxt;
  logic flag_nxt;
  logic [bdd_pkg::ACC_W-1:0] rounded;

  always_comb begin
    rounded       = acc.acc + bdd_pkg::ROUND_HALF;
    j5_nxt.margin = acc.margin;
    j5_nxt.expv   = rounded[bdd_pkg::ACC_W-1:bdd_pkg::FRAC_W];
    j5_nxt.lhs    = bdd_pkg::LHS_W'(acc.duty) * bdd_pkg::DUTY_SCALE;
  end

  always_comb begin
    j6_nxt.rhs = bdd_pkg::CMP_W'(j5_r.expv) * bdd_pkg::CMP_W'(j5_r.margin);
    j6_nxt.lhs = bdd_pkg::CMP_W'(j5_r.lhs);
  end

  assign flag_nxt = j6_r.lhs > j6_r.rhs;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      j5_r <= j5_nxt;
    end
    if (en[1]) begin
      j6_r <= j6_nxt;
    end
    if (en[2]) begin
      flag_r <= flag_nxt;
    end
  end

endmodule

>>> rtl/blocked_duct_detector.sv
// ---------------------------------------------------------------------------
// Blocked duct detector
// Flags a blocked duct when the duty exceeds the banded expected duty.
// ---------------------------------------------------------------------------
// The detector takes one item per clock while in_tready is high and returns
// one flag for every item through a seven-stage pipeline: band and fit start,
// three Horner steps of the quartic fit, rounding, margin scaling and the
// final compare. Each stage carries its own valid bit, so a stalled output
// holds only the stages behind it that are full and empty stages keep taking
// items.
module blocked_duct_detector #(
  parameter int SPEED_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // Fields from bit 0: fan_speed_rpm[SPEED_BITS], duty_fraction[16], zero fill.
  input  logic [((SPEED_BITS + bdd_pkg::DUTY_W + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // Fields from bit 0: duct_blocked[1], zero fill.
  output logic [7:0]                                out_tdata
);

  localparam int NSTAGE = 7;
  localparam int OUT_W  = 8;

  logic [NSTAGE-1:0] en;
  logic [NSTAGE-1:0] vld_r;
  bdd_pkg::s1_t      s1_r;
  bdd_pkg::acc_t     acc_r;
  logic              flag_r;

  bdd_flow #(
    .NSTAGE(NSTAGE)
  ) u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .en        (en),
    .vld_r     (vld_r)
  );

  bdd_front #(
    .SPEED_BITS(SPEED_BITS)
  ) u_front (
    .clk   (clk),
    .en    (en[0]),
    .speed (in_tdata[SPEED_BITS-1:0]),
    .duty  (in_tdata[SPEED_BITS +: bdd_pkg::DUTY_W]),
    .s1_r  (s1_r)
  );

  bdd_poly u_poly (
    .clk   (clk),
    .en    (en[3:1]),
    .s1    (s1_r),
    .acc_r (acc_r)
  );

  bdd_judge u_judge (
    .clk    (clk),
    .en     (en[6:4]),
    .acc    (acc_r),
    .flag_r (flag_r)
  );

  assign out_tvalid = vld_r[NSTAGE-1];
  assign out_tdata  = {{(OUT_W - 1){1'b0}}, flag_r};

`include "blocked_duct_detector_assert.svh"

  `BDD_ASSERT_NOW(a_ready_when_out_empty, clk, rst_n, !out_tvalid, in_tready)
  `BDD_ASSERT_NOW(a_full_stall_blocks, clk, rst_n, out_tvalid && !out_tready && (&vld_r), !in_tready)
  `BDD_ASSERT_NEXT(a_accept_fills_front, clk, rst_n, in_tvalid && in_tready, vld_r[0])

endmodule
